/* src/cgs_pkg.sv */
`timescale 1ns / 1ps
package cgs_pkg;

   localparam int MAX_STOPS   = 16;
   localparam int STOP_AW     = $clog2(MAX_STOPS);
   localparam int MAX_ENTRIES = 4096;
   localparam int POSTER_MAX  = 1024;

   localparam int DIV_N = 24;
   localparam int DIV_D = 13;
   localparam int DIV_Q = 11;

   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_STOP_COUNT = 2'd0,
      REG_RESOLUTION = 2'd1,
      REG_CYCLIC     = 2'd2,
      REG_POSTERIZE  = 2'd3
   } reg_type;

   typedef struct packed {
      logic               valid;
      cmd_type            cmd;
      logic [STOP_AW-1:0] slot;
      logic [23:0]        rgb;
      logic [11:0]        idx;
      status_type         status;
      logic [4:0]         n;
      logic [4:0]         segs;
      logic [11:0]        un;
      logic [12:0]        ud;
      logic [10:0]        post;
      logic [22:0]        prod;
      logic [15:0]        t;
      logic [STOP_AW-1:0] seg;
      logic [12:0]        fn;
   } pipe_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [11:0] echo;
      status_type  status;
   } result_type;

endpackage

/* src/cgs_div.sv */
`timescale 1ns / 1ps
module cgs_div (
   input  logic                       clock,
   input  logic                       en,
   input  logic [cgs_pkg::DIV_N-1:0]  num,
   input  logic [cgs_pkg::DIV_D-1:0]  den,
   output logic [cgs_pkg::DIV_Q-1:0]  quo
);
   import cgs_pkg::*;

   // restoring division, one quotient bit per stage; needs num < den << DIV_Q
   logic [DIV_N-1:0] rem_ff [DIV_Q];
   logic [DIV_D-1:0] den_ff [DIV_Q];
   logic [DIV_Q-1:0] quo_ff [DIV_Q];

   genvar s;
   for (s = 0; s < DIV_Q; s++) begin : g_stage
      logic [DIV_N-1:0] rem_i;
      logic [DIV_N-1:0] dsh;
      logic [DIV_D-1:0] den_i;
      logic [DIV_Q-1:0] quo_i;
      logic             ge;

      if (s == 0) begin : g_first
         assign rem_i = num;
         assign den_i = den;
         assign quo_i = '0;
      end else begin : g_next
         assign rem_i = rem_ff[s-1];
         assign den_i = den_ff[s-1];
         assign quo_i = quo_ff[s-1];
      end

      assign dsh = DIV_N'(den_i) << (DIV_Q - 1 - s);
      assign ge  = (rem_i >= dsh);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= ge ? (rem_i - dsh) : rem_i;
            den_ff[s] <= den_i;
            quo_ff[s] <= quo_i | (DIV_Q'(ge) << (DIV_Q - 1 - s));
         end
      end
   end

   assign quo = quo_ff[DIV_Q-1];

endmodule

/* src/color_gradient_sampler_core.sv */
`timescale 1ns / 1ps
// Throughput: one request per cycle while req_stall is low; three 11-stage
// pipelined dividers in series (band, segment, per-channel) and the stop
// memory read stage set the depth. Loads give no response.
// A stalled response is held in an output register plus one skid entry.
// Reset (synchronous): clears valids and restores register defaults; stop
// memory contents are undefined until loaded.
module color_gradient_sampler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [3:0]  req_stop_slot,
   input  logic [7:0]  req_stop_red,
   input  logic [7:0]  req_stop_green,
   input  logic [7:0]  req_stop_blue,
   input  logic [11:0] req_entry_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_color_red,
   output logic [7:0]  rsp_color_green,
   output logic [7:0]  rsp_color_blue,
   output logic [11:0] rsp_entry_echo,
   output logic [1:0]  rsp_status,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   import cgs_pkg::*;

   logic [4:0]  stop_count_ff;
   logic [12:0] resolution_ff;
   logic        cyclic_ff;
   logic [10:0] posterize_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= 5'd2;
         resolution_ff <= 13'd256;
         cyclic_ff     <= 1'b0;
         posterize_ff  <= 11'd0;
      end else if (csr_we) begin
         case (reg_type'(csr_index))
            REG_STOP_COUNT: stop_count_ff <= csr_wdata[4:0];
            REG_RESOLUTION: resolution_ff <= csr_wdata;
            REG_CYCLIC:     cyclic_ff     <= csr_wdata[0];
            REG_POSTERIZE:  posterize_ff  <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   logic pipe_en;
   logic skid_valid_ff;
   logic accept;

   assign pipe_en   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;

   // stage 0: capture
   pipe_type p0_ff, p0_in;
   always_comb begin
      p0_in        = '0;
      p0_in.valid  = accept;
      p0_in.cmd    = cmd_type'(req_command);
      p0_in.slot   = req_stop_slot;
      p0_in.rgb    = {req_stop_red, req_stop_green, req_stop_blue};
      p0_in.idx    = req_entry_index;
   end

   // stage 1: limits, status, position, product for band division
   pipe_type p1_ff, p1_in;
   logic [4:0]  n_c;
   logic [12:0] res_c;
   always_comb begin
      p1_in = p0_ff;
      n_c   = (stop_count_ff > 5'(MAX_STOPS)) ? 5'(MAX_STOPS) : stop_count_ff;
      res_c = (resolution_ff > 13'(MAX_ENTRIES)) ? 13'(MAX_ENTRIES) : resolution_ff;
      p1_in.n    = n_c;
      p1_in.segs = n_c - 5'd1 + 5'(cyclic_ff);
      if (n_c == 5'd0) begin
         p1_in.status = ST_EMPTY;
      end else if ({1'b0, p0_ff.idx} >= res_c) begin
         p1_in.status = ST_RANGE;
      end else begin
         p1_in.status = ST_OK;
      end
      if (res_c <= 13'd1) begin
         p1_in.un = 12'd0;
         p1_in.ud = 13'd1;
      end else begin
         p1_in.un = p0_ff.idx;
         p1_in.ud = res_c - 13'd1;
      end
      p1_in.post = (posterize_ff > 11'(POSTER_MAX)) ? 11'(POSTER_MAX) : posterize_ff;
      p1_in.prod = 23'(p1_in.un) * 23'(p1_in.post);
   end

   localparam int DLY = DIV_Q;

   pipe_type d1_ff [DLY];
   pipe_type d2_ff [DLY];
   pipe_type d3_ff [DLY];
   logic [DIV_Q-1:0] q1, q2, q3 [3];

   cgs_div u_div_band (
      .clock (clock),
      .en    (pipe_en),
      .num   (DIV_N'(p1_ff.prod)),
      .den   (p1_ff.ud),
      .quo   (q1)
   );

   // stage 2: posterize snap and t = u * segs
   pipe_type p2_ff, p2_in;
   pipe_type e1;
   logic [10:0] band_c;
   always_comb begin
      e1     = d1_ff[DLY-1];
      p2_in  = e1;
      band_c = (q1 > (e1.post - 11'd1)) ? (e1.post - 11'd1) : q1;
      if (e1.post >= 11'd2) begin
         p2_in.un = {band_c, 1'b1};
         p2_in.ud = {1'b0, e1.post, 1'b0};
      end
      p2_in.t = 16'(17'(p2_in.un) * 17'(e1.segs));
   end

   cgs_div u_div_seg (
      .clock (clock),
      .en    (pipe_en),
      .num   (DIV_N'(p2_ff.t)),
      .den   (p2_ff.ud),
      .quo   (q2)
   );

   // stage 3: segment, fraction, stop memory access
   pipe_type p3_ff, p3_in;
   pipe_type e2;
   logic [4:0]  segm1_c, seg_c, nxt_c;
   logic [17:0] segud_c;
   always_comb begin
      e2      = d2_ff[DLY-1];
      p3_in   = e2;
      segm1_c = e2.segs - 5'd1;
      if (e2.segs == 5'd0) begin
         seg_c = 5'd0;
      end else if (q2 > 11'(segm1_c)) begin
         seg_c = segm1_c;
      end else begin
         seg_c = q2[4:0];
      end
      segud_c  = 18'(seg_c) * 18'(e2.ud);
      p3_in.fn = 13'(18'(e2.t) - segud_c);
      if (e2.segs == 5'd0) begin
         p3_in.fn = 13'd0;
      end
      nxt_c     = ((seg_c + 5'd1) >= e2.n) ? 5'd0 : (seg_c + 5'd1);
      p3_in.seg = seg_c[STOP_AW-1:0];
   end

   logic [23:0] stop_mem [MAX_STOPS];
   logic [23:0] rd_a_ff, rd_b_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         if (e2.valid && e2.cmd == CMD_LOAD) begin
            stop_mem[e2.slot] <= e2.rgb;
         end
         rd_a_ff <= stop_mem[seg_c[STOP_AW-1:0]];
         rd_b_ff <= stop_mem[nxt_c[STOP_AW-1:0]];
      end
   end

   // stage 4: weighted sums, numerators for rounding division
   pipe_type p4_ff;
   logic [DIV_N-1:0] num_ff [3];
   logic [DIV_N-1:0] num_in [3];
   logic [12:0]      wa_c;
   always_comb begin
      wa_c = p3_ff.ud - p3_ff.fn;
      for (int c = 0; c < 3; c++) begin
         num_in[c] = ((DIV_N'(rd_a_ff[16-8*c +: 8]) * DIV_N'(wa_c)
                     + DIV_N'(rd_b_ff[16-8*c +: 8]) * DIV_N'(p3_ff.fn)) << 1)
                     + DIV_N'(p3_ff.ud);
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_chan
      cgs_div u_div_chan (
         .clock (clock),
         .en    (pipe_en),
         .num   (num_ff[c]),
         .den   ({p4_ff.ud[11:0], 1'b0}),
         .quo   (q3[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_ff.valid <= 1'b0;
         p1_ff.valid <= 1'b0;
         p2_ff.valid <= 1'b0;
         p3_ff.valid <= 1'b0;
         p4_ff.valid <= 1'b0;
         for (int i = 0; i < DLY; i++) begin
            d1_ff[i].valid <= 1'b0;
            d2_ff[i].valid <= 1'b0;
            d3_ff[i].valid <= 1'b0;
         end
      end else if (pipe_en) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
         p4_ff <= p3_ff;
         num_ff <= num_in;
         d1_ff[0] <= p1_ff;
         d2_ff[0] <= p2_ff;
         d3_ff[0] <= p4_ff;
         for (int i = 1; i < DLY; i++) begin
            d1_ff[i] <= d1_ff[i-1];
            d2_ff[i] <= d2_ff[i-1];
            d3_ff[i] <= d3_ff[i-1];
         end
      end
   end

   // response: output register plus skid entry
   pipe_type   e3;
   logic       res_v;
   result_type result_c;
   always_comb begin
      e3              = d3_ff[DLY-1];
      res_v           = e3.valid && e3.cmd == CMD_SAMPLE;
      result_c.echo   = e3.idx;
      result_c.status = e3.status;
      if (e3.status == ST_OK) begin
         result_c.red   = q3[0][7:0];
         result_c.green = q3[1][7:0];
         result_c.blue  = q3[2][7:0];
      end else begin
         result_c.red   = 8'd0;
         result_c.green = 8'd0;
         result_c.blue  = 8'd0;
      end
   end

   logic       out_valid_ff;
   result_type out_ff, skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!rsp_stall) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || !rsp_stall) begin
         out_valid_ff <= res_v;
         out_ff       <= result_c;
      end else if (res_v) begin
         skid_ff       <= result_c;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_color_red   = out_ff.red;
   assign rsp_color_green = out_ff.green;
   assign rsp_color_blue  = out_ff.blue;
   assign rsp_entry_echo  = out_ff.echo;
   assign rsp_status      = out_ff.status;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a response in the output register");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_stall) && $past(out_valid_ff))
      else $error("skid entry filled while the output was free");

   a_fraction_bound: assert property (@(posedge clock) disable iff (reset)
      (p3_ff.valid && p3_ff.cmd == CMD_SAMPLE && p3_ff.status == ST_OK)
      |-> p3_ff.fn <= p3_ff.ud)
      else $error("interpolation fraction above one");

   a_seg_bound: assert property (@(posedge clock) disable iff (reset)
      (p3_ff.valid && p3_ff.cmd == CMD_SAMPLE && p3_ff.status == ST_OK
       && p3_ff.segs != 5'd0)
      |-> 5'(p3_ff.seg) < p3_ff.segs)
      else $error("segment index beyond last segment");

endmodule
